// File: hw/rtl/sbc_pkg.sv
// sbc_pkg: shared types and constants for the stereo bitcrusher
// no dependencies; imported by the controller, datapath and quantiser lane
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int LEVELS_W   = 8;
  localparam int REM_W      = LEVELS_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_LEVELS = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] HOLD_COUNT_RST   = CFG_DATA_W'(1);
  localparam logic [CFG_DATA_W-1:0] QUANT_LEVELS_RST = CFG_DATA_W'(0);

  typedef struct packed {
    logic                in_load;
    logic                mul;
    logic                div_step;
    logic                div_first;
    logic                capture;
    logic                quant_en;
    logic                out_load;
    logic [LEVELS_W-1:0] quant_levels;
  } sbc_cmd_t;

endpackage

// File: hw/rtl/sbc_if.sv
// sbc_if: valid/ready channel interfaces for frames, results and register writes
// depends on sbc_pkg for the configuration port widths
`timescale 1ns / 1ps

interface sbc_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          block_start;

  modport source (output valid, left_sample, right_sample, block_start, input ready);
  modport sink   (input valid, left_sample, right_sample, block_start, output ready);
endinterface

interface sbc_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface sbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbc_pkg::CFG_IDX_W-1:0]  index;
  logic [sbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sbc_ctrl.sv
// sbc_ctrl: frame sequencer, hold counter and register file
// depends on sbc_pkg; drives the command struct into sbc_datapath
`timescale 1ns / 1ps

module sbc_ctrl #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_block_start,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              cfg_valid,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              cfg_ready,
  output sbc_pkg::sbc_cmd_t                 cmd
);
  import sbc_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CAP,
    S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LEVELS_W-1:0]   hold_pos_r, hold_pos_nxt;
  logic [CFG_DATA_W-1:0] hold_count_r, hold_count_nxt;
  logic [CFG_DATA_W-1:0] quant_levels_r, quant_levels_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [LEVELS_W-1:0]   n_eff, pos_a, pos_b, pos_inc;
  logic                  accept, capture, quant_on, slot_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;
  assign quant_on  = (quant_levels_r != '0);
  assign slot_free = !out_valid_r || out_ready;

  // hold counter arithmetic, zero count behaves as one
  always_comb begin
    n_eff   = (hold_count_r == '0) ? LEVELS_W'(1) : hold_count_r;
    pos_a   = in_block_start ? '0 : hold_pos_r;
    pos_b   = (pos_a >= n_eff) ? '0 : pos_a;
    capture = (pos_b == '0);
    pos_inc = pos_b + LEVELS_W'(1);
    if (pos_inc >= n_eff) begin
      pos_inc = '0;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    hold_pos_nxt     = hold_pos_r;
    hold_count_nxt   = hold_count_r;
    quant_levels_nxt = quant_levels_r;
    out_valid_nxt    = out_valid_r;

    cmd              = '0;
    cmd.quant_en     = quant_on;
    cmd.quant_levels = quant_levels_r;
    cmd.in_load      = accept;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_COUNT:   hold_count_nxt   = cfg_data;
        REG_QUANT_LEVELS: quant_levels_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          hold_pos_nxt = pos_inc;
          if (!capture) begin
            state_nxt = S_OUT;
          end else if (quant_on) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_CAP;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        cmd.capture = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cnt_r          <= '0;
      hold_pos_r     <= '0;
      hold_count_r   <= HOLD_COUNT_RST;
      quant_levels_r <= QUANT_LEVELS_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      hold_pos_r     <= hold_pos_nxt;
      hold_count_r   <= hold_count_nxt;
      quant_levels_r <= quant_levels_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted item did not start processing");

  a_out_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> slot_free)
    else $error("result register overwritten while still held");

  a_div_ends_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_CAP))
    else $error("divider sequence did not finish in capture");

  a_mul_needs_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> quant_on)
    else $error("quantiser started with zero levels");

endmodule

// File: hw/rtl/sbc_quant.sv
// sbc_quant: one channel of the quantiser, magnitude multiply then restoring divide
// depends on sbc_pkg for the command struct; used twice by sbc_datapath
`timescale 1ns / 1ps

module sbc_quant #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  sbc_pkg::sbc_cmd_t             cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] value_o
);
  import sbc_pkg::*;

  localparam int FRAC = SAMPLE_BITS - 1;
  localparam int PROD_W = SAMPLE_BITS + 1 + LEVELS_W;

  logic [SAMPLE_BITS-1:0] raw_r;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;

  logic                   neg;
  logic [SAMPLE_BITS:0]   mag;
  logic [PROD_W-1:0]      prod;
  logic [REM_W-1:0]       trial, divisor;
  logic                   qbit;
  logic [SAMPLE_BITS-1:0] qmag;

  assign neg     = raw_r[SAMPLE_BITS-1];
  assign mag     = neg ? (~{raw_r[SAMPLE_BITS-1], raw_r} + (SAMPLE_BITS+1)'(1))
                       : {1'b0, raw_r};
  assign prod    = {{LEVELS_W{1'b0}}, mag} * {{(SAMPLE_BITS+1){1'b0}}, cmd.quant_levels};
  assign divisor = {1'b0, cmd.quant_levels};

  // first step takes k unshifted, the rest shift the partial remainder
  always_comb begin
    trial   = cmd.div_first ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    qbit    = (trial >= divisor);
    rem_nxt = qbit ? (trial - divisor) : trial;
    quo_nxt = {quo_r[SAMPLE_BITS-2:0], qbit};
  end

  assign qmag    = quo_r;
  assign value_o = !cmd.quant_en ? raw_r : (neg ? (~qmag + SAMPLE_BITS'(1)) : qmag);

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      raw_r <= sample_i;
    end
    if (cmd.mul) begin
      rem_r <= prod[FRAC+REM_W-1:FRAC];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
    end
  end

endmodule

// File: hw/rtl/sbc_datapath.sv
// sbc_datapath: two quantiser lanes, held pair and result register
// depends on sbc_pkg and sbc_quant; steered by sbc_ctrl commands
`timescale 1ns / 1ps

module sbc_datapath #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  sbc_pkg::sbc_cmd_t             cmd,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  input  logic                          rst_n
);
  import sbc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic signed [SAMPLE_BITS-1:0] held_left_r, held_right_r;
  logic signed [SAMPLE_BITS-1:0] left_out_r, right_out_r;

  sbc_quant #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk      (clk),
    .cmd      (cmd),
    .sample_i (left_sample),
    .value_o  (left_q)
  );

  sbc_quant #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk      (clk),
    .cmd      (cmd),
    .sample_i (right_sample),
    .value_o  (right_q)
  );

  // held pair resets to zero as it is observable state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_left_r  <= '0;
      held_right_r <= '0;
    end else if (cmd.capture) begin
      held_left_r  <= left_q;
      held_right_r <= right_q;
    end
    if (cmd.out_load) begin
      left_out_r  <= held_left_r;
      right_out_r <= held_right_r;
    end
  end

  assign left_out  = left_out_r;
  assign right_out = right_out_r;

endmodule

// File: hw/rtl/stereo_bitcrusher_top.sv
// stereo_bitcrusher_top: sample-and-hold plus magnitude quantiser for stereo frames
// depends on sbc_pkg, sbc_if, sbc_ctrl, sbc_datapath
//
//   channel | direction | payload                              | handshake
//   in_ch   | sink      | left_sample, right_sample, block_start | valid/ready
//   out_ch  | source    | left_out, right_out                  | valid/ready
//   cfg_ch  | sink      | index, data                          | valid/ready, always ready
//
// a held frame goes from accept straight to the output state; a captured frame without
// quantisation passes through capture first; a quantised capture passes through multiply,
// the steps of the bit-per-cycle restoring divider in each lane, capture and output
// one item in flight; the next is accepted once the current one sits in the result register
// a stalled result keeps the item waiting and in ready low until the result register frees
// synchronous active-low reset restores hold count 1, quantisation off, held pair zero
`timescale 1ns / 1ps

module stereo_bitcrusher_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sbc_in_if.sink    in_ch,
  sbc_out_if.source out_ch,
  sbc_cfg_if.sink   cfg_ch
);
  import sbc_pkg::*;

  sbc_cmd_t cmd;

  sbc_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_block_start (in_ch.block_start),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .cfg_ready      (cfg_ch.ready),
    .cmd            (cmd)
  );

  sbc_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .left_out     (out_ch.left_out),
    .right_out    (out_ch.right_out),
    .rst_n        (rst_n)
  );

endmodule
